### rtl/core/assert_macros.svh
// assertion helpers for the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rps_pkg;
    localparam int unsigned MaxEntriesDef = 64;
    localparam logic [31:0] LcgMul = 32'd1103515245;
    localparam logic [31:0] LcgAdd = 32'd12345;
    localparam logic [31:0] MinPad = 32'd1;
    localparam int unsigned ValueW = 38;
    localparam int unsigned DivW = 31;

    localparam logic [1:0] KIND_RESEED  = 2'd0;
    localparam logic [1:0] KIND_PAD     = 2'd1;
    localparam logic [1:0] KIND_SHUFFLE = 2'd2;

    localparam logic [2:0] REG_SEED      = 3'd0;
    localparam logic [2:0] REG_HEAP_ST   = 3'd1;
    localparam logic [2:0] REG_HEAP_PAD  = 3'd2;
    localparam logic [2:0] REG_MAP_ST    = 3'd3;
    localparam logic [2:0] REG_MAP_PAD   = 3'd4;
    localparam logic [2:0] REG_PAGE      = 3'd5;
    localparam logic [2:0] REG_SHUF_EN   = 3'd6;

    localparam logic [2:0] REGION_HEAP_ST  = 3'd0;
    localparam logic [2:0] REGION_HEAP     = 3'd1;
    localparam logic [2:0] REGION_MAP_ST   = 3'd2;
    localparam logic [2:0] REGION_MAP      = 3'd3;

    typedef struct packed {
        logic start;
        logic [DivW-1:0] dividend;
        logic [DivW-1:0] divisor;
    } t_div_req;
endpackage
`default_nettype wire

### rtl/core/random_padding_and_shuffle_top.sv
`timescale 1ns / 1ps
`default_nettype none
// reseed: no word out; invalid or disabled padding: word registered on the accept
// padding: word after draw, remainder in the 31-step remainder unit, multiply and output
// register; shuffle of n with shuffling off: one word a cycle while the output is not stalled
// shuffle of n with shuffling on: fill of the n list entries, then per entry a draw, the
// remainder and a list read, then the entries above the pick move down by one
// one item at a time, next taken once the last word is handed over; synchronous active-low
// reset clears control, generator and registers (page size 4096)
module random_padding_and_shuffle_top
    import rps_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_kind,
    input  wire logic [2:0]         i_region,
    input  wire logic [6:0]         i_entry_count,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [ValueW-1:0] o_value,
    output logic                    o_bad_region,
    output logic                    o_last
);
    localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DRAW, S_DIV, S_MUL, S_OUT, S_SHOW, S_FILL, S_RD, S_RDW, S_MOVE, S_SOUT
    } t_state;

    // configuration registers
    logic [31:0] r_seed;
    logic [30:0] r_heap_st, r_heap_pad;
    logic [20:0] r_map_st, r_map_pad;
    logic [16:0] r_page;
    logic        r_shuf_en;

    t_state      r_state;
    logic [31:0] r_gen;
    logic [30:0] r_max;
    logic        r_is_map;
    logic [6:0]  r_n, r_k, r_rcnt;
    logic [6:0]  r_pos;
    logic [30:0] r_rem_v;
    logic        r_ovalid;
    logic [ValueW-1:0] r_oval;
    logic        r_obad, r_olast;
    logic [47:0] r_prod;
    logic        r_mv_first;

    // remaining list memory
    logic [IdxW-1:0] r_mem [MAX_ENTRIES];
    logic [IdxW-1:0] r_rdata;
    logic [IdxW-1:0] n_raddr;
    logic            n_we;
    logic [IdxW-1:0] n_waddr, n_wdata;

    t_div_req  n_div;
    logic      w_div_done;
    logic [DivW-1:0] w_rem;

    rps_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (n_div),
        .o_done (w_div_done),
        .o_rem  (w_rem)
    );

    logic        w_accept;
    logic        w_out_take;
    logic [31:0] w_next_gen;
    logic [6:0]  w_n_clip;
    logic [30:0] w_sel_max;

    assign w_accept   = i_valid && !o_stall;
    assign w_out_take = r_ovalid && !i_stall;
    assign o_stall    = (r_state != S_IDLE) || r_ovalid;
    assign w_next_gen = r_gen * LcgMul + LcgAdd;
    assign w_n_clip   = (i_entry_count > 7'(MAX_ENTRIES)) ? 7'(MAX_ENTRIES) : i_entry_count;

    always_comb begin
        case (i_region)
            REGION_HEAP_ST: w_sel_max = r_heap_st;
            REGION_HEAP:    w_sel_max = r_heap_pad;
            REGION_MAP_ST:  w_sel_max = {10'd0, r_map_st};
            REGION_MAP:     w_sel_max = {10'd0, r_map_pad};
            default:        w_sel_max = '0;
        endcase
    end

    // divider start: dividend is the fresh draw
    always_comb begin
        n_div.start    = (r_state == S_DRAW);
        n_div.dividend = w_next_gen[30:0];
        n_div.divisor  = r_max;
    end

    // memory port control
    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_k[IdxW-1:0];
        n_wdata = r_k[IdxW-1:0];
        n_raddr = r_pos[IdxW-1:0];
        case (r_state)
            S_FILL: n_we = 1'b1;
            S_MOVE: begin
                n_raddr = IdxW'(r_pos + 7'd1);
                if (!r_mv_first) begin
                    n_we    = 1'b1;
                    n_waddr = IdxW'(r_pos - 7'd1);
                    n_wdata = r_rdata;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_waddr] <= n_wdata;
        r_rdata <= r_mem[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0; r_heap_st <= '0; r_heap_pad <= '0;
            r_map_st <= '0; r_map_pad <= '0; r_page <= 17'd4096; r_shuf_en <= 1'b0;
            r_state <= S_IDLE;
            r_gen <= '0;
            r_ovalid <= 1'b0;
            r_n <= '0; r_k <= '0; r_rcnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SEED:     r_seed     <= i_cfg_data;
                    REG_HEAP_ST:  r_heap_st  <= i_cfg_data[30:0];
                    REG_HEAP_PAD: r_heap_pad <= i_cfg_data[30:0];
                    REG_MAP_ST:   r_map_st   <= i_cfg_data[20:0];
                    REG_MAP_PAD:  r_map_pad  <= i_cfg_data[20:0];
                    REG_PAGE:     r_page     <= i_cfg_data[16:0];
                    REG_SHUF_EN:  r_shuf_en  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // in-order output loads the next word on the same take
            if (w_out_take && (r_state != S_SOUT)) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_kind)
                            KIND_RESEED: r_gen <= r_seed;
                            KIND_PAD: begin
                                r_is_map <= (i_region == REGION_MAP_ST) ||
                                            (i_region == REGION_MAP);
                                r_max    <= w_sel_max;
                                r_n <= 7'd1; r_k <= 7'd0;
                                if (i_region > REGION_MAP) begin
                                    r_ovalid <= 1'b1; r_oval <= '1;
                                    r_obad <= 1'b1; r_olast <= 1'b1;
                                end else if (w_sel_max == '0) begin
                                    r_ovalid <= 1'b1; r_oval <= '0;
                                    r_obad <= 1'b0; r_olast <= 1'b1;
                                end else begin
                                    r_state <= S_DRAW;
                                end
                            end
                            KIND_SHUFFLE: begin
                                r_n <= w_n_clip; r_k <= '0;
                                r_rcnt <= '0;
                                if (w_n_clip != '0) r_state <= r_shuf_en ? S_FILL : S_SOUT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FILL: begin
                    if (r_k + 7'd1 == r_n) begin
                        r_k <= '0; r_rcnt <= r_n;
                        r_max <= {24'd0, r_n};
                        r_state <= S_DRAW;
                    end else begin
                        r_k <= r_k + 7'd1;
                    end
                end
                S_DRAW: begin
                    r_gen <= w_next_gen;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_rem_v <= w_rem;
                        if (r_rcnt != '0) begin
                            r_pos <= w_rem[6:0];
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod <= 48'(r_rem_v + MinPad) * (r_is_map ? 48'(r_page) : 48'd1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_oval <= (r_prod > 48'((64'd1 << 37) - 1)) ?
                                  ValueW'((64'd1 << 37) - 1) : r_prod[ValueW-1:0];
                        r_obad <= 1'b0; r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_mv_first <= 1'b1;
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    // picked entry now on read data
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_oval <= ValueW'(r_rdata);
                        r_obad <= 1'b0;
                        r_olast <= (r_k + 7'd1 == r_n);
                        r_state <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    // shift entries above the pick down by one, a read ahead of each write
                    r_mv_first <= 1'b0;
                    if (r_pos + 7'd1 >= r_rcnt) begin
                        r_rcnt <= r_rcnt - 7'd1;
                        r_max <= {24'd0, r_rcnt - 7'd1};
                        r_k <= r_k + 7'd1;
                        r_state <= (r_k + 7'd1 == r_n) ? S_IDLE : S_DRAW;
                    end else begin
                        r_pos <= r_pos + 7'd1;
                    end
                end
                S_SOUT: begin
                    if (!r_ovalid || w_out_take) begin
                        r_ovalid <= 1'b1;
                        r_oval <= ValueW'(r_k);
                        r_obad <= 1'b0;
                        r_olast <= (r_k + 7'd1 == r_n);
                        r_k <= r_k + 7'd1;
                        if (r_k + 7'd1 == r_n) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_value      = $signed(r_oval);
    assign o_bad_region = r_obad;
    assign o_last       = r_olast;

`include "assert_macros.svh"
    `ASSERT_IMPL(a_stall_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall, "busy block not stalling")
    `ASSERT_IMPL(a_bad_last, i_clk, i_rst_n, o_valid && o_bad_region, o_last, "bad region word not last")
    `ASSERT_NEXT(a_take_stall, i_clk, i_rst_n, w_accept && i_kind == KIND_PAD, o_stall, "pad item not held")
endmodule
`default_nettype wire

### rtl/core/rps_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// restoring radix-2 remainder unit, one quotient bit per cycle
module rps_divider
    import rps_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_div_req        i_req,
    output logic                 o_done,
    output logic [DivW-1:0]      o_rem
);
    logic [DivW-1:0] r_rem, r_dvd, r_dvs;
    logic [4:0]      r_cnt;
    logic            r_busy, r_done;
    logic [DivW:0]   n_trial;
    logic [DivW:0]   n_shift;

    assign n_shift = {r_rem, r_dvd[DivW-1]};
    assign n_trial = n_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_trial[DivW] ? n_shift[DivW-1:0] : n_trial[DivW-1:0];
                r_dvd <= {r_dvd[DivW-2:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(DivW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire
